/* hw/rtl/mcdn_pkg.sv */
// ----------------------------------------------------------------------------
// mcdn_pkg
// Types and constants shared by the masked column dot product block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcdn_pkg;

  localparam int unsigned VAL_W     = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned CNT_FIELD_MAX = 2047;

  // Divider and square root engine widths.
  localparam int unsigned DQ_W      = 56;  // |sum| * 256 needs 56 bits
  localparam int unsigned SQ_W      = 28;  // count << 16, padded to an even width
  localparam int unsigned ROOT_W    = 14;
  localparam int unsigned REM_W     = 17;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned SQRT_STEPS = SQ_W / 2;
  localparam int unsigned DIV_STEPS  = DQ_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_LAST,
    ST_WAIT,
    ST_EMIT
  } mcdn_state_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SQRT,
    ENG_DIV,
    ENG_DONE
  } mcdn_eng_state_t;

  typedef struct packed {
    logic             start;
    logic             use_root;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] mag;
  } mcdn_eng_cmd_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } mcdn_eng_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/masked_column_dot_normalize.sv */
// ----------------------------------------------------------------------------
// masked_column_dot_normalize
// Masked column dot product with division by the present count or its root.
// ----------------------------------------------------------------------------
// Each element item is accepted, its 16x16 product is registered, and the
// product is added to the saturating 48-bit sum. An item marked last then runs
// the shared subtract unit of the divide and square root engine: a division in
// mode 0, and a square root followed by a division in mode 1. When every
// element was missing the engine is not started. The result is then held until
// the output takes it. The input is stalled while an item is in progress.
// scale_mode is to be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_column_dot_normalize
  import mcdn_pkg::*;
#(
  parameter int unsigned MAX_COLUMN_LENGTH = 1024
)
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    cfg_wr_en,
  input  wire logic                    cfg_wr_data,

  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [VAL_W-1:0] in_matrix_value,
  input  wire logic                    in_value_missing,
  input  wire logic signed [VAL_W-1:0] in_vector_value,
  input  wire logic                    in_last_in_column,

  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [SUM_W-1:0]      out_column_result,
  output logic [CNT_W-1:0]             out_present_total,
  output logic                         out_all_missing
);

  localparam int unsigned CNT_LIMIT =
    (MAX_COLUMN_LENGTH < CNT_FIELD_MAX) ? MAX_COLUMN_LENGTH : CNT_FIELD_MAX;

  mcdn_state_t state_r, state_nxt;

  logic                     mode_r;
  logic signed [VAL_W-1:0]  mv_r, vv_r;
  logic                     miss_r, last_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     neg_r;
  logic signed [SUM_W-1:0]  res_r, res_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0]  out_result_r;
  logic [CNT_W-1:0]         out_total_r;
  logic                     out_missing_r;

  logic                     in_take;
  logic                     slot_free;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;

  mcdn_eng_cmd_t            eng_cmd;
  mcdn_eng_rsp_t            eng_rsp;

  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Saturating accumulate of the registered product.
  always_comb begin
    sum_wide = {sum_r[SUM_W-1], sum_r} + {{(SUM_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_r ? ST_LAST : ST_IDLE;
      ST_LAST: state_nxt = (cnt_r == '0) ? ST_EMIT : ST_WAIT;
      ST_WAIT: begin
        if (eng_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    eng_cmd.start    = 1'b0;
    eng_cmd.use_root = mode_r;
    eng_cmd.count    = cnt_r;
    eng_cmd.mag      = sum_r[SUM_W-1] ? -sum_r : sum_r;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_MUL: begin
        prod_nxt = mv_r * vv_r;
      end
      ST_ACC: begin
        if (!miss_r) begin
          sum_nxt = sum_sat;
          if (cnt_r < CNT_W'(CNT_LIMIT)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_LAST: begin
        res_nxt = '0;
        eng_cmd.start = (cnt_r != '0);
      end
      ST_WAIT: begin
        if (eng_rsp.done) begin
          res_nxt = neg_r ? -eng_rsp.quotient : eng_rsp.quotient;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          cnt_nxt       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    if (in_take) begin
      mv_r   <= in_matrix_value;
      vv_r   <= in_vector_value;
      miss_r <= in_value_missing;
      last_r <= in_last_in_column;
    end
    if (state_r == ST_LAST) begin
      neg_r <= sum_r[SUM_W-1];
    end
    if (state_r == ST_EMIT && slot_free) begin
      out_result_r  <= res_r;
      out_total_r   <= cnt_r;
      out_missing_r <= (cnt_r == '0);
    end
  end

  mcdn_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (eng_cmd),
    .rsp   (eng_rsp)
  );

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_column_result = out_result_r;
  assign out_present_total = out_total_r;
  assign out_all_missing   = out_missing_r;

endmodule

`default_nettype wire

/* hw/rtl/mcdn_divsqrt.sv */
// ----------------------------------------------------------------------------
// mcdn_divsqrt
// Iterative engine around one shared subtract-and-compare unit: an optional
// integer square root of count << 16 (two bits a cycle), then a restoring
// division of the magnitude (one quotient bit a cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module mcdn_divsqrt
  import mcdn_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mcdn_eng_cmd_t cmd,
  output mcdn_eng_rsp_t      rsp
);

  mcdn_eng_state_t state_r, state_nxt;

  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ROOT_W-1:0] divisor_r, divisor_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [DQ_W-1:0]   dq_r, dq_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Shared unit operands.
  logic [REM_W-1:0]  partial;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              ge;

  always_comb begin
    case (state_r)
      ENG_SQRT: begin
        partial = {rem_r[REM_W-3:0], sq_r[SQ_W-1 -: 2]};
        trial   = {1'b0, root_r, 2'b01};
      end
      default: begin
        partial = {rem_r[REM_W-2:0], dq_r[DQ_W-1]};
        trial   = {{(REM_W-ROOT_W){1'b0}}, divisor_r};
      end
    endcase
    diff = {1'b0, partial} - {1'b0, trial};
    ge   = ~diff[REM_W];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (cmd.start) begin
          state_nxt = cmd.use_root ? ENG_SQRT : ENG_DIV;
        end
      end
      ENG_SQRT: begin
        if (step_r == STEP_W'(1)) begin
          state_nxt = ENG_DIV;
        end
      end
      ENG_DIV: begin
        if (step_r == STEP_W'(1)) begin
          state_nxt = ENG_DONE;
        end
      end
      ENG_DONE: state_nxt = ENG_IDLE;
      default:  state_nxt = ENG_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt     = rem_r;
    root_nxt    = root_r;
    divisor_nxt = divisor_r;
    sq_nxt      = sq_r;
    dq_nxt      = dq_r;
    step_nxt    = step_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (cmd.start) begin
          rem_nxt     = '0;
          root_nxt    = '0;
          divisor_nxt = {{(ROOT_W-CNT_W){1'b0}}, cmd.count};
          sq_nxt      = {1'b0, cmd.count, 16'h0000};
          // In root mode the dividend is scaled by 256 ahead of the division.
          dq_nxt      = cmd.use_root ? {cmd.mag, 8'h00} : {8'h00, cmd.mag};
          step_nxt    = cmd.use_root ? STEP_W'(SQRT_STEPS) : STEP_W'(DIV_STEPS);
        end
      end
      ENG_SQRT: begin
        rem_nxt  = ge ? diff[REM_W-1:0] : partial;
        root_nxt = {root_r[ROOT_W-2:0], ge};
        sq_nxt   = {sq_r[SQ_W-3:0], 2'b00};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          divisor_nxt = {root_r[ROOT_W-2:0], ge};
          rem_nxt     = '0;
          step_nxt    = STEP_W'(DIV_STEPS);
        end
      end
      ENG_DIV: begin
        rem_nxt  = ge ? diff[REM_W-1:0] : partial;
        dq_nxt   = {dq_r[DQ_W-2:0], ge};
        step_nxt = step_r - STEP_W'(1);
      end
      ENG_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    divisor_r <= divisor_nxt;
    sq_r      <= sq_nxt;
    dq_r      <= dq_nxt;
    step_r    <= step_nxt;
  end

  // The quotient never exceeds 2^47, so the low 48 bits hold it whole.
  assign rsp.done     = (state_r == ENG_DONE);
  assign rsp.quotient = dq_r[SUM_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/mcdn_checker.sv */
// ----------------------------------------------------------------------------
// mcdn_checker
// Port-level checks for the masked column dot product block.
// ----------------------------------------------------------------------------
`default_nettype none

module mcdn_checker
  import mcdn_pkg::*;
#(
  parameter int unsigned MAX_COLUMN_LENGTH = 1024
)
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [SUM_W-1:0] out_column_result,
  input wire logic [CNT_W-1:0]        out_present_total,
  input wire logic                    out_all_missing
);

  localparam int unsigned CNT_LIMIT =
    (MAX_COLUMN_LENGTH < CNT_FIELD_MAX) ? MAX_COLUMN_LENGTH : CNT_FIELD_MAX;

  // An empty column reports a zero result and a zero count.
  a_empty_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_all_missing |-> out_column_result == '0 && out_present_total == '0)
    else $error("empty column reported a non-zero result or count");

  a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_all_missing |-> out_present_total != '0)
    else $error("present count zero without the all-missing flag");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_present_total <= CNT_W'(CNT_LIMIT))
    else $error("present count above its limit");

  // Each item is worked through the multiply and accumulate states, so the input is busy after one is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_column_result))
    else $error("stalled result item changed or was dropped");

endmodule

bind masked_column_dot_normalize mcdn_checker #(
  .MAX_COLUMN_LENGTH(MAX_COLUMN_LENGTH)
) u_mcdn_checker (.*);

`default_nettype wire

/* tb/sv/masked_column_dot_normalize_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_column_dot_normalize_checker
// Watches the configuration port and both item channels of the masked column
// dot product block. It keeps its own running sum, present count and scale
// mode, works out each column result when the last element is taken, and
// compares the results leaving the block against them in order.
// ----------------------------------------------------------------------------
module masked_column_dot_normalize_checker
  import mcdn_pkg::*;
#(
  parameter int unsigned MAX_COLUMN_LENGTH = 1024
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [VAL_W-1:0]  in_matrix_value,
  input  logic                     in_value_missing,
  input  logic signed [VAL_W-1:0]  in_vector_value,
  input  logic                     in_last_in_column,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [SUM_W-1:0]  out_column_result,
  input  logic [CNT_W-1:0]         out_present_total,
  input  logic                     out_all_missing,
  output int                       mismatch_count,
  output int                       columns_pending
);

  localparam longint SUM_HIGH = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LOW  = -SUM_HIGH - 1;
  localparam int unsigned COUNT_CEILING =
    (MAX_COLUMN_LENGTH < CNT_FIELD_MAX) ? MAX_COLUMN_LENGTH : CNT_FIELD_MAX;

  typedef struct packed {
    logic signed [SUM_W-1:0] column_result;
    logic [CNT_W-1:0]        present_total;
    logic                    all_missing;
  } column_outcome_t;

  column_outcome_t expected_columns[$];
  longint          column_sum;
  int unsigned     column_present;
  logic            scale_by_root;

  // Largest r with r*r <= v, built one bit at a time from the top.
  function automatic longint floor_root(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic column_outcome_t close_column(input longint sum, input int unsigned cnt,
                                                   input logic by_root);
    column_outcome_t outcome;
    longint          quotient;
    quotient = 0;
    if (cnt != 0) begin
      if (!by_root) quotient = sum / longint'(cnt);
      else quotient = (sum * 256) / floor_root(longint'(cnt) << 16);
    end
    outcome.column_result = quotient[SUM_W-1:0];
    outcome.present_total = cnt[CNT_W-1:0];
    outcome.all_missing   = (cnt == 0);
    return outcome;
  endfunction

  always @(posedge clk) begin
    column_outcome_t want;
    longint          next_sum;
    if (!rst_n) begin
      expected_columns.delete();
      column_sum      = 0;
      column_present  = 0;
      scale_by_root   = 1'b0;
      mismatch_count  = 0;
      columns_pending = 0;
    end else begin
      if (cfg_wr_en) scale_by_root = cfg_wr_data;

      if (out_valid && !out_stall) begin
        if (expected_columns.size() == 0) begin
          $display("%0t: unexpected result item: result=%0d total=%0d all_missing=%0b",
                   $time, out_column_result, out_present_total, out_all_missing);
          mismatch_count++;
        end else begin
          want = expected_columns.pop_front();
          if (out_column_result !== want.column_result) begin
            $display("%0t: column_result expected %0d, got %0d",
                     $time, want.column_result, out_column_result);
            mismatch_count++;
          end
          if (out_present_total !== want.present_total) begin
            $display("%0t: present_total expected %0d, got %0d",
                     $time, want.present_total, out_present_total);
            mismatch_count++;
          end
          if (out_all_missing !== want.all_missing) begin
            $display("%0t: all_missing expected %0b, got %0b",
                     $time, want.all_missing, out_all_missing);
            mismatch_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (!in_value_missing) begin
          next_sum = column_sum + longint'(in_matrix_value) * longint'(in_vector_value);
          if (next_sum > SUM_HIGH) next_sum = SUM_HIGH;
          if (next_sum < SUM_LOW) next_sum = SUM_LOW;
          column_sum = next_sum;
          if (column_present < COUNT_CEILING) column_present++;
        end
        if (in_last_in_column) begin
          expected_columns.push_back(close_column(column_sum, column_present, scale_by_root));
          column_sum     = 0;
          column_present = 0;
        end
      end

      columns_pending = expected_columns.size();
    end
  end

endmodule

/* tb/sv/masked_column_dot_normalize_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_column_dot_normalize_tb
// Drives columns of matrix and vector elements into the block under both scale
// modes: a directed set of extremes, then random columns with random idling on
// one, both or neither channel and one long hold on the result side. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module masked_column_dot_normalize_tb;
  import mcdn_pkg::*;

  localparam int unsigned COLUMN_LENGTH_MAX = 1024;
  localparam logic SCALE_BY_COUNT = 1'b0;
  localparam logic SCALE_BY_ROOT  = 1'b1;
  localparam int   SETTLE_CYCLES  = 100;
  localparam int   HOLD_CYCLES    = 300;
  localparam int   WATCHDOG_LIMIT = 4000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic                    cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_matrix_value;
  logic                    in_value_missing;
  logic signed [VAL_W-1:0] in_vector_value;
  logic                    in_last_in_column;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SUM_W-1:0] out_column_result;
  logic [CNT_W-1:0]        out_present_total;
  logic                    out_all_missing;

  int mismatch_count;
  int columns_pending;
  int quiet_cycles;
  bit sender_idles;
  bit receiver_idles;
  bit hold_request;

  masked_column_dot_normalize #(
    .MAX_COLUMN_LENGTH(COLUMN_LENGTH_MAX)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_matrix_value   (in_matrix_value),
    .in_value_missing  (in_value_missing),
    .in_vector_value   (in_vector_value),
    .in_last_in_column (in_last_in_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_column_result (out_column_result),
    .out_present_total (out_present_total),
    .out_all_missing   (out_all_missing)
  );

  masked_column_dot_normalize_checker #(
    .MAX_COLUMN_LENGTH(COLUMN_LENGTH_MAX)
  ) checker_inst (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_matrix_value   (in_matrix_value),
    .in_value_missing  (in_value_missing),
    .in_vector_value   (in_vector_value),
    .in_last_in_column (in_last_in_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_column_result (out_column_result),
    .out_present_total (out_present_total),
    .out_all_missing   (out_all_missing),
    .mismatch_count    (mismatch_count),
    .columns_pending   (columns_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Any cycle that moves an item on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("masked_column_dot_normalize_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: a random hold before each item when receiver_idles is set, or one long hold on request.
  initial begin
    int gap;
    out_stall = 1'b1;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 16);
      if (!receiver_idles) gap = 0;
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 15) - 8);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic offer_element(input logic [VAL_W-1:0] mv, input logic missing,
                               input logic [VAL_W-1:0] vv, input logic last);
    int gap;
    gap = $urandom_range(0, 16);
    if (!sender_idles) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_matrix_value   <= mv;
    in_value_missing  <= missing;
    in_vector_value   <= vv;
    in_last_in_column <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain every outstanding column and let the engine settle, then set the mode.
  task automatic set_scale_mode(input logic mode);
    in_valid <= 1'b0;
    while (columns_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_columns(input int items);
    int   sent;
    int   len;
    int   missing_kind;
    logic missing;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      missing_kind = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        case (missing_kind)
          0: missing = 1'b0;
          1: missing = 1'b1;
          default: missing = ($urandom_range(0, 9) < 3);
        endcase
        offer_element(pick_value(), missing, pick_value(), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    in_valid          = 1'b0;
    in_matrix_value   = '0;
    in_value_missing  = 1'b0;
    in_vector_value   = '0;
    in_last_in_column = 1'b0;
    sender_idles      = 1'b1;
    receiver_idles    = 1'b1;
    hold_request      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme single products, an all-missing column and rounding toward zero.
    offer_element(16'h7FFF, 1'b0, 16'h7FFF, 1'b1);
    offer_element(16'h8000, 1'b0, 16'h8000, 1'b1);
    offer_element(16'h8000, 1'b0, 16'h7FFF, 1'b1);
    offer_element(16'h0100, 1'b1, 16'h0100, 1'b0);
    offer_element(16'h1234, 1'b1, 16'hFFFF, 1'b0);
    offer_element(16'h8000, 1'b1, 16'h7FFF, 1'b1);
    offer_element(16'hFFFD, 1'b0, 16'h0001, 1'b0);
    offer_element(16'h0000, 1'b0, 16'h0005, 1'b1);
    offer_element(16'h0000, 1'b0, 16'h0000, 1'b1);
    set_scale_mode(SCALE_BY_ROOT);
    offer_element(16'h7FFF, 1'b0, 16'h7FFF, 1'b1);
    offer_element(16'h8000, 1'b0, 16'h7FFF, 1'b1);
    offer_element(16'h0100, 1'b0, 16'h0100, 1'b0);
    offer_element(16'hFF00, 1'b0, 16'h0100, 1'b0);
    offer_element(16'h0080, 1'b1, 16'h0080, 1'b1);
    offer_element(16'h5555, 1'b1, 16'hAAAA, 1'b1);
    offer_element(16'hFFFF, 1'b0, 16'h0001, 1'b0);
    offer_element(16'h0001, 1'b0, 16'h0001, 1'b0);
    offer_element(16'hFFFF, 1'b0, 16'h0003, 1'b1);

    set_scale_mode(SCALE_BY_COUNT);
    random_columns(100);

    set_scale_mode(SCALE_BY_ROOT);
    hold_request = 1'b1;
    random_columns(100);

    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    set_scale_mode(SCALE_BY_COUNT);
    random_columns(100);

    sender_idles = 1'b1;
    set_scale_mode(SCALE_BY_ROOT);
    random_columns(100);

    sender_idles   = 1'b0;
    receiver_idles = 1'b1;
    set_scale_mode(1'($urandom_range(0, 1)));
    random_columns(100);

    in_valid <= 1'b0;
    while (columns_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("masked_column_dot_normalize_tb: clean");
    end else begin
      $display("masked_column_dot_normalize_tb: errors");
    end
    $finish;
  end

endmodule
